// File: hw/rtl/ic_pkg.sv
// shared constants and types for the inversion counter
package ic_pkg;

    localparam int DATA_W        = 32;
    localparam int INV_W         = 19;
    localparam int MAX_ITEMS_DEF = 1024;

    localparam logic [INV_W-1:0] INV_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/ic_ram.sv
// element memory: one write port, two registered read ports, write-first
module ic_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ic_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr_l,
    input  logic [AW-1:0]             i_raddr_r,
    output logic [ic_pkg::DATA_W-1:0] o_rdata_l,
    output logic [ic_pkg::DATA_W-1:0] o_rdata_r
);
    import ic_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_l;
    logic [DATA_W-1:0] r_rdata_r;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // bypass so a read of the entry being written returns the new word
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr_l)) begin
            r_rdata_l <= i_wdata;
        end else begin
            r_rdata_l <= mem[i_raddr_l];
        end
        if (i_we && (i_waddr == i_raddr_r)) begin
            r_rdata_r <= i_wdata;
        end else begin
            r_rdata_r <= mem[i_raddr_r];
        end
    end

    assign o_rdata_l = r_rdata_l;
    assign o_rdata_r = r_rdata_r;

endmodule

// File: hw/rtl/ic_ctrl.sv
// load and bottom-up merge sequencer with inversion tally
module ic_ctrl #(
    parameter int MAX_ITEMS = 1024,
    parameter int AW        = 10
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic signed [ic_pkg::DATA_W-1:0] i_value,
    input  logic                             i_is_last,
    output logic                             busy,
    output logic                             o_valid,
    output logic [ic_pkg::INV_W-1:0]         o_inversions,
    output logic                             o_overflow,
    input  logic [ic_pkg::DATA_W-1:0]        i_a_rdata_l,
    input  logic [ic_pkg::DATA_W-1:0]        i_a_rdata_r,
    input  logic [ic_pkg::DATA_W-1:0]        i_b_rdata_l,
    input  logic [ic_pkg::DATA_W-1:0]        i_b_rdata_r,
    output logic [AW-1:0]                    o_raddr_l,
    output logic [AW-1:0]                    o_raddr_r,
    output logic                             o_a_we,
    output logic [AW-1:0]                    o_a_waddr,
    output logic [ic_pkg::DATA_W-1:0]        o_a_wdata,
    output logic                             o_b_we,
    output logic [AW-1:0]                    o_b_waddr,
    output logic [ic_pkg::DATA_W-1:0]        o_b_wdata
);
    import ic_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int WW = CW + 1;
    localparam int EW = CW + 3;
    localparam int TW = (2 * CW > INV_W) ? 2 * CW : INV_W + 1;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_drop, n_drop;
    logic [TW-1:0] r_total, n_total;
    logic [WW-1:0] r_w, n_w;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic          r_src, n_src;

    logic              accept;
    logic              full;
    logic [CW-1:0]     len_in;
    logic [CW-1:0]     seg_len;
    logic [DATA_W-1:0] head_l;
    logic [DATA_W-1:0] head_r;
    logic              l_ok;
    logic              r_ok;
    logic              take_l;
    logic              seg_end;
    logic              pass_end;
    logic              sort_done;
    logic [CW-1:0]     seg_lo;
    logic [WW-1:0]     seg_w;
    logic [EW-1:0]     last_e;
    logic [EW-1:0]     mid_e;
    logic [EW-1:0]     hi_e;
    logic [CW-1:0]     left_rem;

    assign accept  = start && (r_state == ST_IDLE);
    assign full    = (r_cnt == CW'(MAX_ITEMS));
    assign len_in  = full ? r_cnt : r_cnt + CW'(1);
    assign seg_len = (r_state == ST_IDLE) ? len_in : r_cnt;

    assign head_l = r_src ? i_b_rdata_l : i_a_rdata_l;
    assign head_r = r_src ? i_b_rdata_r : i_a_rdata_r;
    assign l_ok   = (r_i <= r_mid);
    assign r_ok   = (r_j <= r_hi);
    assign take_l = l_ok && (!r_ok || ($signed(head_l) <= $signed(head_r)));

    assign seg_end   = (r_k == r_hi);
    assign pass_end  = seg_end && ((r_hi + CW'(1)) == r_cnt);
    assign sort_done = pass_end && ((r_w << 1) >= WW'(r_cnt));
    assign left_rem  = r_mid - r_i + CW'(1);

    // bounds of the next run pair, clamped to the sequence end
    always_comb begin
        if (r_state == ST_IDLE || pass_end) begin
            seg_lo = '0;
        end else begin
            seg_lo = r_hi + CW'(1);
        end
        if (r_state == ST_IDLE) begin
            seg_w = WW'(1);
        end else if (pass_end) begin
            seg_w = r_w << 1;
        end else begin
            seg_w = r_w;
        end
        last_e = EW'(seg_len) - EW'(1);
        mid_e  = EW'(seg_lo) + EW'(seg_w) - EW'(1);
        hi_e   = EW'(seg_lo) + (EW'(seg_w) << 1) - EW'(1);
        if (mid_e > last_e) begin
            mid_e = last_e;
        end
        if (hi_e > last_e) begin
            hi_e = last_e;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_is_last) begin
                    n_state = (len_in < CW'(2)) ? ST_DONE : ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (sort_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_total = r_total;
        n_w     = r_w;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_src   = r_src;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cnt  = len_in;
                    n_drop = r_drop || full;
                    if (i_is_last) begin
                        n_w   = seg_w;
                        n_i   = seg_lo;
                        n_k   = seg_lo;
                        n_mid = CW'(mid_e);
                        n_j   = CW'(mid_e) + CW'(1);
                        n_hi  = CW'(hi_e);
                        n_src = 1'b0;
                    end
                end
            end
            ST_MERGE: begin
                if (!take_l) begin
                    n_total = r_total + TW'(left_rem);
                end
                if (seg_end) begin
                    n_w   = seg_w;
                    n_i   = seg_lo;
                    n_k   = seg_lo;
                    n_mid = CW'(mid_e);
                    n_j   = CW'(mid_e) + CW'(1);
                    n_hi  = CW'(hi_e);
                    if (pass_end) begin
                        n_src = ~r_src;
                    end
                end else begin
                    n_k = r_k + CW'(1);
                    if (take_l) begin
                        n_i = r_i + CW'(1);
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            ST_DONE: begin
                n_cnt   = '0;
                n_drop  = 1'b0;
                n_total = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_src <= n_src;
    end

    // memory ports and result
    always_comb begin
        o_raddr_l    = n_i[AW-1:0];
        o_raddr_r    = n_j[AW-1:0];
        o_a_we       = 1'b0;
        o_a_waddr    = r_k[AW-1:0];
        o_a_wdata    = take_l ? head_l : head_r;
        o_b_we       = 1'b0;
        o_b_waddr    = r_k[AW-1:0];
        o_b_wdata    = take_l ? head_l : head_r;
        busy         = (r_state != ST_IDLE);
        o_valid      = (r_state == ST_DONE);
        o_overflow   = r_drop;
        o_inversions = (r_total > TW'(INV_MAX)) ? INV_MAX : r_total[INV_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !full) begin
                    o_a_we    = 1'b1;
                    o_a_waddr = r_cnt[AW-1:0];
                    o_a_wdata = i_value;
                end
            end
            ST_MERGE: begin
                o_a_we = r_src;
                o_b_we = ~r_src;
            end
            ST_DONE: begin
                o_a_we = 1'b0;
            end
            default: begin
                o_a_we = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/inversion_counter.sv
// inversion counter top level: two ping-pong element memories and the merge sequencer
//
// Input: a beat is taken when start is high and busy is low. Each beat carries
// one signed 32-bit element in i_value; i_is_last closes the sequence.
// Beats load back to back while busy is low. Elements past MAX_ITEMS are
// dropped and reported through o_overflow.
// After the closing beat the block runs a bottom-up merge sort between two
// memories, one output element per cycle, in ceil(log2 N) passes over all N
// elements. busy stays high throughout.
// Output: o_valid is high for one cycle with o_inversions (pairs where the
// earlier element is greater, saturated to 19 bits) and o_overflow. The
// receiver cannot stall; the result is gone after that cycle.
// A sequence of one element gives 0 in the cycle after its beat.
// Reset clears the element count, the tally and the overflow flag; memory
// contents are left as they are and only entries of the current sequence are
// read.
module inversion_counter #(
    parameter int MAX_ITEMS = ic_pkg::MAX_ITEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic signed [ic_pkg::DATA_W-1:0] i_value,
    input  logic                             i_is_last,
    output logic                             busy,
    output logic                             o_valid,
    output logic [ic_pkg::INV_W-1:0]         o_inversions,
    output logic                             o_overflow
);
    import ic_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [AW-1:0]     raddr_l;
    logic [AW-1:0]     raddr_r;
    logic              a_we;
    logic [AW-1:0]     a_waddr;
    logic [DATA_W-1:0] a_wdata;
    logic              b_we;
    logic [AW-1:0]     b_waddr;
    logic [DATA_W-1:0] b_wdata;
    logic [DATA_W-1:0] a_rdata_l;
    logic [DATA_W-1:0] a_rdata_r;
    logic [DATA_W-1:0] b_rdata_l;
    logic [DATA_W-1:0] b_rdata_r;

    ic_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (a_we),
        .i_waddr   (a_waddr),
        .i_wdata   (a_wdata),
        .i_raddr_l (raddr_l),
        .i_raddr_r (raddr_r),
        .o_rdata_l (a_rdata_l),
        .o_rdata_r (a_rdata_r)
    );

    ic_ram #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (b_we),
        .i_waddr   (b_waddr),
        .i_wdata   (b_wdata),
        .i_raddr_l (raddr_l),
        .i_raddr_r (raddr_r),
        .o_rdata_l (b_rdata_l),
        .o_rdata_r (b_rdata_r)
    );

    ic_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_value      (i_value),
        .i_is_last    (i_is_last),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_inversions (o_inversions),
        .o_overflow   (o_overflow),
        .i_a_rdata_l  (a_rdata_l),
        .i_a_rdata_r  (a_rdata_r),
        .i_b_rdata_l  (b_rdata_l),
        .i_b_rdata_r  (b_rdata_r),
        .o_raddr_l    (raddr_l),
        .o_raddr_r    (raddr_r),
        .o_a_we       (a_we),
        .o_a_waddr    (a_waddr),
        .o_a_wdata    (a_wdata),
        .o_b_we       (b_we),
        .o_b_waddr    (b_waddr),
        .o_b_wdata    (b_wdata)
    );

endmodule
